/* rtl/core/learned_route_forward_table_top_assert.svh */
// ----------------------------------------------------------------------------
// Learned route forwarding table: assertion macros
// Shared concurrent assertion forms, clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LEARNED_ROUTE_FORWARD_TABLE_TOP_ASSERT_SVH
`define LEARNED_ROUTE_FORWARD_TABLE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRFT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LRFT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/lrft_pkg.sv */
// ----------------------------------------------------------------------------
// Learned route forwarding table: package
// Widths, codes, score weights and the types shared by the controller,
// the datapath and the top level.
// ----------------------------------------------------------------------------
package lrft_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    localparam int ADDR_W      = 16;
    localparam int ENERGY_W    = 7;
    localparam int LQI_W       = 8;
    localparam int HOPS_W      = 8;
    localparam int SEQ_W       = 16;
    localparam int ID_W        = 16;
    localparam int CODE_W      = 3;
    localparam int NSIZE_W     = 8;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 56;

    localparam int INNER_W = 16;
    localparam int HOPT_W  = 22;
    localparam int SCORE_W = 24;
    localparam int CMP_W   = 28;

    localparam logic KIND_INSTALL = 1'b0;
    localparam logic KIND_HEADER  = 1'b1;

    localparam logic [CODE_W-1:0] LEARN_NONE     = 3'd0;
    localparam logic [CODE_W-1:0] LEARN_NEW      = 3'd1;
    localparam logic [CODE_W-1:0] LEARN_REPLACED = 3'd2;
    localparam logic [CODE_W-1:0] LEARN_KEPT     = 3'd3;
    localparam logic [CODE_W-1:0] LEARN_FULL     = 3'd4;

    localparam logic [CODE_W-1:0] ACT_NONE      = 3'd0;
    localparam logic [CODE_W-1:0] ACT_DELIVERED = 3'd1;
    localparam logic [CODE_W-1:0] ACT_FORWARD   = 3'd2;
    localparam logic [CODE_W-1:0] ACT_BLOCKED   = 3'd3;
    localparam logic [CODE_W-1:0] ACT_NO_ROUTE  = 3'd4;
    localparam logic [CODE_W-1:0] ACT_MALFORMED = 3'd5;

    localparam logic [CFG_INDEX_W-1:0] CFG_MY_ADDRESS   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NETWORK_SIZE = 8'd1;

    localparam logic [ADDR_W-1:0]  MY_ADDRESS_RST   = 16'd1;
    localparam logic [NSIZE_W-1:0] NETWORK_SIZE_RST = 8'd4;

    localparam logic [ENERGY_W-1:0] LEARN_ENERGY = 7'd100;
    localparam logic [HOPS_W-1:0]   LEARN_HOPS   = 8'd1;

    localparam logic [INNER_W-1:0] LQI_COEF        = 16'd100;
    localparam logic [INNER_W-1:0] ENERGY_COEF     = 16'd153;
    localparam logic [INNER_W-1:0] NEW_ENERGY_TERM = 16'd15300;
    localparam logic [HOPT_W-1:0]  HOP_WEIGHT      = 22'd10200;

    typedef struct packed {
        logic [ADDR_W-1:0]   dst;
        logic [ADDR_W-1:0]   next;
        logic [ENERGY_W-1:0] energy;
        logic [LQI_W-1:0]    lqi;
        logic [HOPS_W-1:0]   hops;
    } route_t;

    typedef struct packed {
        logic              capture;
        logic              rd_en;
        logic              key_dst;
        logic              wr_en;
        logic              wr_use_hit;
        logic              fwd_set;
        logic              out_load;
        logic [CODE_W-1:0] learn_code;
        logic [CODE_W-1:0] action_code;
    } dp_cmd_t;

    typedef struct packed {
        logic kind;
        logic header_ok;
        logic sender_is_me;
        logic dst_is_me;
        logic hit;
        logic free_found;
        logic better;
        logic next_is_sender;
    } dp_stat_t;

endpackage

/* rtl/core/learned_route_forward_table_top.sv */
// A header that learns and then looks up scans the table twice, an install scans
// it once and a malformed header goes straight to the result; each lookup scans
// one table entry per cycle. One item at a time: the next is accepted no earlier
// than the cycle after the result is loaded, and the load waits while the result
// register still holds an unaccepted result.
// Reset clears the valid bits, the id counter and the handshakes, not the memory.
// ----------------------------------------------------------------------------
// Learned route forwarding table: top level
// Stream ports, configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
module learned_route_forward_table_top #(
    parameter int TABLE_ENTRIES = lrft_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // sender_addr, dst_addr, next_hop, energy, link_quality, hop_count,
    // seq_num, header_ok
    input  logic [lrft_pkg::IN_TDATA_W-1:0]       s_tdata,
    // kind
    input  logic [0:0]                            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // learn_status, forward_action, forward_hop, seq_out, entry_id, zero fill
    output logic [lrft_pkg::OUT_TDATA_W-1:0]      m_tdata,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lrft_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [lrft_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import lrft_pkg::*;

    logic [ADDR_W-1:0]  my_addr_reg;
    logic [NSIZE_W-1:0] net_size_reg;

    dp_cmd_t                          cmd;
    dp_stat_t                         stat;
    logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr;

    logic                      res_no_fwd;
    logic                      res_no_write;
    logic [ADDR_W+SEQ_W-1:0]   res_hop_seq;
    logic [ID_W-1:0]           res_id;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            my_addr_reg  <= MY_ADDRESS_RST;
            net_size_reg <= NETWORK_SIZE_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MY_ADDRESS:   my_addr_reg  <= cfg_data;
                CFG_NETWORK_SIZE: net_size_reg <= cfg_data[NSIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    lrft_controller #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .stat    (stat),
        .cmd     (cmd),
        .rd_addr (rd_addr)
    );

    lrft_datapath #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .in_tdata (s_tdata),
        .in_tuser (s_tuser[0]),
        .my_addr  (my_addr_reg),
        .net_size (net_size_reg),
        .stat     (stat),
        .out_tdata(m_tdata)
    );

    assign res_no_fwd   = m_tvalid && (m_tdata[5:3] != ACT_FORWARD);
    assign res_no_write = m_tvalid && !(m_tdata[2:0] inside {LEARN_NEW, LEARN_REPLACED});
    assign res_hop_seq  = m_tdata[37:6];
    assign res_id       = m_tdata[53:38];

`include "learned_route_forward_table_top_assert.svh"

    `LRFT_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted while busy")
    `LRFT_ASSERT_SAME(a_hop_only_on_forward, res_no_fwd, res_hop_seq == '0, "hop without forward")
    `LRFT_ASSERT_SAME(a_id_only_on_write, res_no_write, res_id == '0, "entry id without a write")

endmodule

/* rtl/core/lrft_datapath.sv */
// ----------------------------------------------------------------------------
// Learned route forwarding table: datapath
// Item registers, route memory with valid bits, scan match logic, score
// pipeline, entry id counter and the result register.
// ----------------------------------------------------------------------------
module lrft_datapath #(
    parameter int TABLE_ENTRIES = lrft_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  lrft_pkg::dp_cmd_t                    cmd,
    input  logic [$clog2(TABLE_ENTRIES)-1:0]     rd_addr,
    input  logic [lrft_pkg::IN_TDATA_W-1:0]      in_tdata,
    input  logic                                 in_tuser,
    input  logic [lrft_pkg::ADDR_W-1:0]          my_addr,
    input  logic [lrft_pkg::NSIZE_W-1:0]         net_size,
    output lrft_pkg::dp_stat_t                   stat,
    output logic [lrft_pkg::OUT_TDATA_W-1:0]     out_tdata
);
    import lrft_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    logic                kind_reg;
    logic [ADDR_W-1:0]   sender_reg;
    logic [ADDR_W-1:0]   dst_reg;
    logic [ADDR_W-1:0]   next_reg;
    logic [ENERGY_W-1:0] energy_reg;
    logic [LQI_W-1:0]    lqi_reg;
    logic [HOPS_W-1:0]   hops_reg;
    logic [SEQ_W-1:0]    seq_reg;
    logic                hok_reg;

    route_t                   mem [TABLE_ENTRIES];
    route_t                   rd_q_reg;
    logic                     rd_pend_reg;
    logic [IDX_W-1:0]         rd_idx_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;

    logic             hit_reg;
    logic             free_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [IDX_W-1:0] free_idx_reg;
    route_t           hit_entry_reg;

    logic [ID_W-1:0]   id_cnt_reg;
    logic [ID_W-1:0]   eid_reg;
    logic [ADDR_W-1:0] fhop_reg;
    logic [SEQ_W-1:0]  sout_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic [INNER_W-1:0] inner_old_reg, inner_old_next;
    logic [INNER_W-1:0] inner_new_reg, inner_new_next;
    logic [HOPT_W-1:0]  hopt_old_reg, hopt_old_next;
    logic [HOPT_W-1:0]  hopt_new_reg, hopt_new_next;
    logic [SCORE_W-1:0] score_old_reg, score_old_next;
    logic [SCORE_W-1:0] score_new_reg, score_new_next;

    logic [NSIZE_W-1:0] n_eff;
    logic [ADDR_W-1:0]  key;
    logic               match;
    logic               empty;
    logic [IDX_W-1:0]   wr_idx;
    route_t             wr_entry;
    logic [HOPS_W-1:0]  hop_diff;

    assign n_eff = (net_size == '0) ? NSIZE_W'(1) : net_size;
    assign key   = (cmd.key_dst || kind_reg == KIND_INSTALL) ? dst_reg : sender_reg;
    assign match = rd_pend_reg && valid_reg[rd_idx_reg] && (rd_q_reg.dst == key);
    assign empty = rd_pend_reg && !valid_reg[rd_idx_reg];
    assign wr_idx = cmd.wr_use_hit ? hit_idx_reg : free_idx_reg;
    assign hop_diff = n_eff - hit_entry_reg.hops;

    always_comb begin
        if (kind_reg == KIND_INSTALL) begin
            wr_entry = '{dst: dst_reg, next: next_reg, energy: energy_reg,
                         lqi: lqi_reg, hops: hops_reg};
        end else begin
            wr_entry = '{dst: sender_reg, next: sender_reg, energy: LEARN_ENERGY,
                         lqi: lqi_reg, hops: LEARN_HOPS};
        end
    end

    always_comb begin
        inner_old_next = INNER_W'({8'd0, hit_entry_reg.lqi} * LQI_COEF)
                       + INNER_W'({9'd0, hit_entry_reg.energy} * ENERGY_COEF);
        inner_new_next = INNER_W'({8'd0, lqi_reg} * LQI_COEF) + NEW_ENERGY_TERM;
        if (hit_entry_reg.hops < n_eff) begin
            hopt_old_next = HOPT_W'(HOPT_W'(hop_diff) * HOP_WEIGHT);
        end else begin
            hopt_old_next = '0;
        end
        if (n_eff > NSIZE_W'(1)) begin
            hopt_new_next = HOPT_W'(HOPT_W'(n_eff - NSIZE_W'(1)) * HOP_WEIGHT);
        end else begin
            hopt_new_next = '0;
        end
        score_old_next = SCORE_W'(SCORE_W'(n_eff) * SCORE_W'(inner_old_reg))
                       + SCORE_W'(hopt_old_reg);
        score_new_next = SCORE_W'(SCORE_W'(n_eff) * SCORE_W'(inner_new_reg))
                       + SCORE_W'(hopt_new_reg);
    end

    always_ff @(posedge aclk) begin
        inner_old_reg <= inner_old_next;
        inner_new_reg <= inner_new_next;
        hopt_old_reg  <= hopt_old_next;
        hopt_new_reg  <= hopt_new_next;
        score_old_reg <= score_old_next;
        score_new_reg <= score_new_next;
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg   <= in_tuser;
            sender_reg <= in_tdata[15:0];
            dst_reg    <= in_tdata[31:16];
            next_reg   <= in_tdata[47:32];
            energy_reg <= in_tdata[54:48];
            lqi_reg    <= in_tdata[62:55];
            hops_reg   <= in_tdata[70:63];
            seq_reg    <= in_tdata[86:71];
            hok_reg    <= in_tdata[87];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[wr_idx] <= wr_entry;
        end
        if (cmd.rd_en) begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= rd_addr;
        if (match && !hit_reg) begin
            hit_idx_reg   <= rd_idx_reg;
            hit_entry_reg <= rd_q_reg;
        end
        if (empty && !free_reg) begin
            free_idx_reg <= rd_idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_pend_reg <= 1'b0;
            valid_reg   <= '0;
            hit_reg     <= 1'b0;
            free_reg    <= 1'b0;
            id_cnt_reg  <= '0;
        end else begin
            rd_pend_reg <= cmd.rd_en;
            if (cmd.rd_en && rd_addr == '0) begin
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end else begin
                if (match) begin
                    hit_reg <= 1'b1;
                end
                if (empty) begin
                    free_reg <= 1'b1;
                end
            end
            if (cmd.wr_en) begin
                valid_reg[wr_idx] <= 1'b1;
                id_cnt_reg        <= id_cnt_reg + ID_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            eid_reg  <= '0;
            fhop_reg <= '0;
            sout_reg <= '0;
        end else begin
            if (cmd.wr_en) begin
                eid_reg <= id_cnt_reg;
            end
            if (cmd.fwd_set) begin
                fhop_reg <= hit_entry_reg.next;
                sout_reg <= seq_reg;
            end
        end
        if (cmd.out_load) begin
            out_data_reg <= {2'b00, eid_reg, sout_reg, fhop_reg,
                             cmd.action_code, cmd.learn_code};
        end
    end

    assign out_tdata = out_data_reg;

    assign stat.kind           = kind_reg;
    assign stat.header_ok      = hok_reg;
    assign stat.sender_is_me   = (sender_reg == my_addr);
    assign stat.dst_is_me      = (dst_reg == my_addr);
    assign stat.hit            = hit_reg;
    assign stat.free_found     = free_reg;
    assign stat.better         = (CMP_W'(score_new_reg) * CMP_W'(10))
                               > (CMP_W'(score_old_reg) * CMP_W'(11));
    assign stat.next_is_sender = (hit_entry_reg.next == sender_reg);

endmodule

/* rtl/core/lrft_controller.sv */
// ----------------------------------------------------------------------------
// Learned route forwarding table: controller
// Sequences the table scans, the score compare, the table write and the
// forwarding decision, and holds the result handshake.
// ----------------------------------------------------------------------------
module lrft_controller #(
    parameter int TABLE_ENTRIES = lrft_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  lrft_pkg::dp_stat_t               stat,
    output lrft_pkg::dp_cmd_t                cmd,
    output logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr
);
    import lrft_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_START   = 4'd1;
    localparam logic [3:0] ST_SCAN_A  = 4'd2;
    localparam logic [3:0] ST_DRAIN_A = 4'd3;
    localparam logic [3:0] ST_SC0     = 4'd4;
    localparam logic [3:0] ST_SC1     = 4'd5;
    localparam logic [3:0] ST_DECIDE  = 4'd6;
    localparam logic [3:0] ST_LKUP    = 4'd7;
    localparam logic [3:0] ST_SCAN_B  = 4'd8;
    localparam logic [3:0] ST_DRAIN_B = 4'd9;
    localparam logic [3:0] ST_LOOK    = 4'd10;
    localparam logic [3:0] ST_FINISH  = 4'd11;

    logic [3:0]        state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CODE_W-1:0] learn_reg, learn_next;
    logic [CODE_W-1:0] action_reg, action_next;
    logic              out_valid_reg, out_valid_next;

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        learn_next  = learn_reg;
        action_next = action_reg;
        cmd         = '0;
        cmd.learn_code  = learn_reg;
        cmd.action_code = action_reg;
        s_tready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    learn_next  = LEARN_NONE;
                    action_next = ACT_NONE;
                    state_next  = ST_START;
                end
            end
            ST_START: begin
                idx_next = '0;
                if (stat.kind == KIND_INSTALL) begin
                    state_next = ST_SCAN_A;
                end else if (!stat.header_ok) begin
                    action_next = ACT_MALFORMED;
                    state_next  = ST_FINISH;
                end else if (stat.sender_is_me) begin
                    state_next = ST_LKUP;
                end else begin
                    state_next = ST_SCAN_A;
                end
            end
            ST_SCAN_A: begin
                cmd.rd_en = 1'b1;
                idx_next  = idx_reg + IDX_W'(1);
                if (idx_reg == LAST_IDX) begin
                    state_next = ST_DRAIN_A;
                end
            end
            ST_DRAIN_A: begin
                state_next = ST_SC0;
            end
            ST_SC0: begin
                state_next = ST_SC1;
            end
            ST_SC1: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.wr_use_hit = stat.hit;
                if (stat.hit) begin
                    if (stat.kind == KIND_INSTALL || stat.better) begin
                        cmd.wr_en  = 1'b1;
                        learn_next = LEARN_REPLACED;
                    end else begin
                        learn_next = LEARN_KEPT;
                    end
                end else if (stat.free_found) begin
                    cmd.wr_en  = 1'b1;
                    learn_next = LEARN_NEW;
                end else begin
                    learn_next = LEARN_FULL;
                end
                state_next = (stat.kind == KIND_INSTALL) ? ST_FINISH : ST_LKUP;
            end
            ST_LKUP: begin
                idx_next = '0;
                if (stat.dst_is_me) begin
                    action_next = ACT_DELIVERED;
                    state_next  = ST_FINISH;
                end else begin
                    state_next = ST_SCAN_B;
                end
            end
            ST_SCAN_B: begin
                cmd.rd_en   = 1'b1;
                cmd.key_dst = 1'b1;
                idx_next    = idx_reg + IDX_W'(1);
                if (idx_reg == LAST_IDX) begin
                    state_next = ST_DRAIN_B;
                end
            end
            ST_DRAIN_B: begin
                cmd.key_dst = 1'b1;
                state_next  = ST_LOOK;
            end
            ST_LOOK: begin
                if (!stat.hit) begin
                    action_next = ACT_NO_ROUTE;
                end else if (stat.next_is_sender) begin
                    action_next = ACT_BLOCKED;
                end else begin
                    action_next = ACT_FORWARD;
                    cmd.fwd_set = 1'b1;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            learn_reg     <= LEARN_NONE;
            action_reg    <= ACT_NONE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            learn_reg     <= learn_next;
            action_reg    <= action_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rd_addr  = idx_reg;
    assign m_tvalid = out_valid_reg;

endmodule
